FILE: src/slpd_pkg.sv
// ----------------------------------------------------------------------------
// slpd_pkg
// Shared types and constants for the sync/length-prefixed byte deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package slpd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned OUT_DATA_W  = 56;
  localparam int unsigned OUT_USER_W  = 2;

  localparam logic [BYTE_W-1:0] SYNC_FIRST    = 8'h94;
  localparam logic [BYTE_W-1:0] SYNC_SECOND   = 8'hC3;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 16'd512;
  localparam logic [LEN_W-1:0]  RESYNC_RESET  = 16'd10;

  // Bit positions inside out_tuser.
  localparam int unsigned TUSER_KIND  = 0;
  localparam int unsigned TUSER_FIRST = 1;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_ABORT   = 1'b1
  } kind_t;

  typedef enum logic {
    CFG_MAX_LEN = 1'b0,
    CFG_RESYNC  = 1'b1
  } cfg_index_t;

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_SYNC2  = 5'b00010,
    PH_LEN_HI = 5'b00100,
    PH_LEN_LO = 5'b01000,
    PH_DATA   = 5'b10000
  } phase_t;

endpackage

`default_nettype wire

FILE: src/sync_length_prefixed_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_prefixed_deframer
// Hunts for the sync pair 0x94 0xC3, reads a big-endian 16-bit length and
// streams the payload bytes out with first and last marks and abort results.
// ----------------------------------------------------------------------------
//  Channel | Direction | Fields
//  in_     | slave     | tdata: rx_byte
//  out_    | master    | tdata: payload_byte, frame_length, frames_completed;
//          |           | tuser: kind, first_of_frame; tlast: last_of_frame
//  cfg_    | write     | index 0 max_payload_length, index 1 resync_threshold
//
// One byte is accepted per cycle; its result appears in the output register
// on the next cycle. The frame state and the output register are updated by
// the same edge. in_tready is low only while a result waits in the output
// register and out_tready is low. Reset is synchronous and takes effect at
// every rising edge with rst_n low; the first cycle after it accepts a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_prefixed_deframer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [slpd_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] rx_byte
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [7:0] payload_byte, [23:8] frame_length, [55:24] frames_completed
  output logic [slpd_pkg::OUT_DATA_W-1:0]         out_tdata,
  // [0] kind, [1] first_of_frame
  output logic [slpd_pkg::OUT_USER_W-1:0]         out_tuser,
  output logic                                    out_tlast,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [slpd_pkg::LEN_W-1:0]         cfg_wdata
);

  slpd_pkg::phase_t               phase_r, phase_nxt;
  logic [slpd_pkg::LEN_W-1:0]     exp_len_r, exp_len_nxt;
  logic [slpd_pkg::LEN_W-1:0]     pay_cnt_r, pay_cnt_nxt;
  logic [slpd_pkg::CNT_W-1:0]     frames_r, frames_nxt;
  logic [slpd_pkg::LEN_W-1:0]     max_len_r;
  logic [slpd_pkg::LEN_W-1:0]     resync_r;

  logic                           out_valid_r;
  logic [slpd_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [slpd_pkg::OUT_USER_W-1:0] out_user_r, out_user_nxt;
  logic                           out_last_r, out_last_nxt;
  logic                           emit;

  logic                           in_xfer;
  logic [slpd_pkg::LEN_W:0]       cnt_inc;
  logic [slpd_pkg::LEN_W-1:0]     len_lo;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign cnt_inc = {1'b0, pay_cnt_r} + {{slpd_pkg::LEN_W{1'b0}}, 1'b1};
  assign len_lo  = {exp_len_r[slpd_pkg::LEN_W-1:slpd_pkg::BYTE_W], in_tdata};

  always_comb begin
    phase_nxt    = phase_r;
    exp_len_nxt  = exp_len_r;
    pay_cnt_nxt  = pay_cnt_r;
    frames_nxt   = frames_r;
    emit         = 1'b0;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    out_last_nxt = out_last_r;

    if (phase_r == slpd_pkg::PH_DATA && in_tdata == slpd_pkg::SYNC_FIRST &&
        pay_cnt_r > resync_r) begin
      emit         = 1'b1;
      out_data_nxt = {frames_r, exp_len_r, {slpd_pkg::BYTE_W{1'b0}}};
      out_user_nxt = '0;
      out_user_nxt[slpd_pkg::TUSER_KIND] = slpd_pkg::KIND_ABORT;
      out_last_nxt = 1'b0;
      phase_nxt    = slpd_pkg::PH_SYNC2;
      pay_cnt_nxt  = '0;
    end else begin
      case (phase_r)
        slpd_pkg::PH_SYNC2: begin
          if (in_tdata == slpd_pkg::SYNC_SECOND) begin
            phase_nxt = slpd_pkg::PH_LEN_HI;
          end else if (in_tdata != slpd_pkg::SYNC_FIRST) begin
            phase_nxt   = slpd_pkg::PH_HUNT;
            pay_cnt_nxt = '0;
            exp_len_nxt = '0;
          end
        end
        slpd_pkg::PH_LEN_HI: begin
          exp_len_nxt = {in_tdata, {slpd_pkg::BYTE_W{1'b0}}};
          phase_nxt   = slpd_pkg::PH_LEN_LO;
        end
        slpd_pkg::PH_LEN_LO: begin
          pay_cnt_nxt = '0;
          if (len_lo == '0 || len_lo > max_len_r) begin
            phase_nxt   = slpd_pkg::PH_HUNT;
            exp_len_nxt = '0;
          end else begin
            phase_nxt   = slpd_pkg::PH_DATA;
            exp_len_nxt = len_lo;
          end
        end
        slpd_pkg::PH_DATA: begin
          emit         = 1'b1;
          out_user_nxt = '0;
          out_user_nxt[slpd_pkg::TUSER_KIND]  = slpd_pkg::KIND_PAYLOAD;
          out_user_nxt[slpd_pkg::TUSER_FIRST] = (pay_cnt_r == '0);
          out_last_nxt = (cnt_inc >= {1'b0, exp_len_r});
          pay_cnt_nxt  = cnt_inc[slpd_pkg::LEN_W-1:0];
          if (out_last_nxt) begin
            frames_nxt  = frames_r + 32'd1;
            phase_nxt   = slpd_pkg::PH_HUNT;
            pay_cnt_nxt = '0;
            exp_len_nxt = '0;
          end
          out_data_nxt = {frames_nxt, exp_len_r, in_tdata};
        end
        default: begin
          pay_cnt_nxt = '0;
          if (in_tdata == slpd_pkg::SYNC_FIRST) begin
            phase_nxt = slpd_pkg::PH_SYNC2;
          end else begin
            phase_nxt = slpd_pkg::PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= slpd_pkg::PH_HUNT;
      exp_len_r   <= '0;
      pay_cnt_r   <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r   <= phase_nxt;
        exp_len_r <= exp_len_nxt;
        pay_cnt_r <= pay_cnt_nxt;
        frames_r  <= frames_nxt;
      end
      if (in_xfer && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= slpd_pkg::MAX_LEN_RESET;
      resync_r  <= slpd_pkg::RESYNC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        slpd_pkg::CFG_MAX_LEN: max_len_r <= cfg_wdata;
        slpd_pkg::CFG_RESYNC:  resync_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
      out_last_r <= out_last_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/slpd_checker.sv
// ----------------------------------------------------------------------------
// slpd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slpd_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [slpd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input wire logic [slpd_pkg::OUT_USER_W-1:0]    out_tuser,
  input wire logic                               out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transfer changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while result register is full");

  a_abort_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[slpd_pkg::TUSER_KIND] |->
      out_tdata[7:0] == 8'h00 && !out_tlast && !out_tuser[slpd_pkg::TUSER_FIRST])
    else $error("abort result carries payload marks");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[slpd_pkg::TUSER_KIND] |-> out_tdata[23:8] != 16'd0)
    else $error("payload result with zero frame length");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sync_length_prefixed_deframer slpd_checker u_slpd_checker (.*);

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Testbench for sync_length_prefixed_deframer
// Drives byte streams built from well-formed frames, aborted and rejected
// frames, broken sync pairs and noise. A frame tracker mirrors the deframer
// state and predicts each payload and abort transfer, which is then compared
// field by field with what the block sends out.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    slpd_pkg::kind_t kind;
    logic [7:0]      data;
    logic            first;
    logic            last;
    logic [15:0]     length;
    logic [31:0]     frames;
  } frame_result_t;

  class deframer_scoreboard;
    frame_result_t    expected_q[$];
    logic [15:0]      max_len;
    logic [15:0]      resync_thr;
    logic [15:0]      announced_len;
    logic [15:0]      rcvd;
    logic [31:0]      frames_done;
    slpd_pkg::phase_t phase;
    int               errors;

    function new();
      max_len = slpd_pkg::MAX_LEN_RESET;
      resync_thr = slpd_pkg::RESYNC_RESET;
      frames_done = '0;
      errors = 0;
      restart_hunt();
    endfunction

    function void restart_hunt();
      phase = slpd_pkg::PH_HUNT;
      rcvd = '0;
      announced_len = '0;
    endfunction

    function void set_register(slpd_pkg::cfg_index_t idx, logic [15:0] value);
      case (idx)
        slpd_pkg::CFG_MAX_LEN: max_len = value;
        slpd_pkg::CFG_RESYNC:  resync_thr = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(logic [7:0] b);
      frame_result_t r;
      if (phase == slpd_pkg::PH_DATA && b == slpd_pkg::SYNC_FIRST && rcvd > resync_thr) begin
        r.kind = slpd_pkg::KIND_ABORT;
        r.data = '0;
        r.first = 1'b0;
        r.last = 1'b0;
        r.length = announced_len;
        r.frames = frames_done;
        expected_q.push_back(r);
        phase = slpd_pkg::PH_SYNC2;
        rcvd = '0;
        return;
      end
      case (phase)
        slpd_pkg::PH_SYNC2: begin
          if (b == slpd_pkg::SYNC_SECOND) begin
            phase = slpd_pkg::PH_LEN_HI;
          end else if (b != slpd_pkg::SYNC_FIRST) begin
            restart_hunt();
          end
        end
        slpd_pkg::PH_LEN_HI: begin
          announced_len = {b, 8'h00};
          phase = slpd_pkg::PH_LEN_LO;
        end
        slpd_pkg::PH_LEN_LO: begin
          announced_len[7:0] = b;
          if (announced_len == 16'd0 || announced_len > max_len) begin
            restart_hunt();
          end else begin
            rcvd = '0;
            phase = slpd_pkg::PH_DATA;
          end
        end
        slpd_pkg::PH_DATA: begin
          r.kind = slpd_pkg::KIND_PAYLOAD;
          r.data = b;
          r.first = (rcvd == 16'd0);
          r.length = announced_len;
          rcvd = rcvd + 16'd1;
          r.last = (rcvd >= announced_len);
          if (r.last) begin
            frames_done = frames_done + 32'd1;
            restart_hunt();
          end
          r.frames = frames_done;
          expected_q.push_back(r);
        end
        default: begin
          if (b == slpd_pkg::SYNC_FIRST) begin
            phase = slpd_pkg::PH_SYNC2;
            rcvd = '0;
          end else begin
            phase = slpd_pkg::PH_HUNT;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected transfer: kind %0d, payload_byte 0x%0h", got.kind, got.data);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("kind", 32'(exp_r.kind), 32'(got.kind));
      compare_field("payload_byte", 32'(exp_r.data), 32'(got.data));
      compare_field("first_of_frame", 32'(exp_r.first), 32'(got.first));
      compare_field("last_of_frame", 32'(exp_r.last), 32'(got.last));
      compare_field("frame_length", 32'(exp_r.length), 32'(got.length));
      compare_field("frames_completed", exp_r.frames, got.frames);
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [slpd_pkg::BYTE_W-1:0]     in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [slpd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [slpd_pkg::OUT_USER_W-1:0] out_tuser;
  logic                            out_tlast;
  logic                            cfg_we;
  logic                            cfg_index;
  logic [slpd_pkg::LEN_W-1:0]      cfg_wdata;

  deframer_scoreboard sb;
  logic [7:0]         stim_q[$];
  int unsigned        idle_max;

  sync_length_prefixed_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic stream_bytes();
    foreach (stim_q[i]) send_byte(stim_q[i]);
    in_tvalid <= 1'b0;
    stim_q.delete();
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input slpd_pkg::cfg_index_t idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_frame_start(input logic [15:0] len);
    stim_q.push_back(slpd_pkg::SYNC_FIRST);
    stim_q.push_back(slpd_pkg::SYNC_SECOND);
    stim_q.push_back(len[15:8]);
    stim_q.push_back(len[7:0]);
  endtask

  task automatic plan_traffic(input int unsigned target, input int unsigned max_len,
                              input int unsigned thr);
    int unsigned pick;
    int unsigned len;
    int unsigned cap;
    logic [7:0]  b;
    cap = (max_len == 0) ? 12 : ((max_len < 12) ? max_len : 12);
    while (stim_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 || (pick < 65 && thr > 30)) begin
        len = $urandom_range(1, cap);
        push_frame_start(16'(len));
        repeat (len) begin
          b = ($urandom_range(0, 9) == 0) ? slpd_pkg::SYNC_FIRST : 8'($urandom);
          stim_q.push_back(b);
        end
      end else if (pick < 65) begin
        len = (max_len > thr + 2) ? $urandom_range(thr + 2, max_len) : thr + 2;
        push_frame_start(16'(len));
        repeat (thr + 1 + $urandom_range(0, 3)) begin
          b = 8'($urandom);
          if (b == slpd_pkg::SYNC_FIRST) b = 8'h00;
          stim_q.push_back(b);
        end
        stim_q.push_back(slpd_pkg::SYNC_FIRST);
      end else if (pick < 75) begin
        if (max_len >= 65535 || $urandom_range(0, 2) == 0) len = 0;
        else len = $urandom_range(max_len + 1, 65535);
        push_frame_start(16'(len));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 3)) stim_q.push_back(slpd_pkg::SYNC_FIRST);
        stim_q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) stim_q.push_back(8'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned   gap;
    int            results_seen;
    frame_result_t got;
    out_tready <= 1'b0;
    results_seen = 0;
    @(negedge clk);
    forever begin
      if (results_seen % 160 == 100) gap = 80;
      else gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.kind = slpd_pkg::kind_t'(out_tuser[slpd_pkg::TUSER_KIND]);
      got.first = out_tuser[slpd_pkg::TUSER_FIRST];
      got.last = out_tlast;
      got.data = out_tdata[7:0];
      got.length = out_tdata[23:8];
      got.frames = out_tdata[55:24];
      sb.check_result(got);
      results_seen++;
      @(negedge clk);
    end
  end

  initial begin
    logic [15:0] max_tbl[6];
    logic [15:0] thr_tbl[6];
    int unsigned size_tbl[6];
    int unsigned gap_tbl[6];
    logic [7:0]  directed[$];
    max_tbl = '{16'hFFFF, 16'd1, 16'd24, 16'd0, 16'd300, 16'd16};
    thr_tbl = '{16'd0, 16'hFFFF, 16'd3, 16'd5, 16'hFFFF, 16'd10};
    size_tbl = '{100, 90, 110, 30, 100, 100};
    gap_tbl = '{18, 0, 18, 18, 6, 18};
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= slpd_pkg::CFG_MAX_LEN;
    cfg_wdata <= '0;
    idle_max = 8;
    sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Repeated first sync byte, then a one-byte frame.
    directed = '{slpd_pkg::SYNC_FIRST, slpd_pkg::SYNC_FIRST, slpd_pkg::SYNC_SECOND,
                 8'h00, 8'h01, 8'hFF};
    // Broken sync pair, zero length, one past the maximum length.
    directed = {directed, slpd_pkg::SYNC_FIRST, 8'h55};
    directed = {directed, slpd_pkg::SYNC_FIRST, slpd_pkg::SYNC_SECOND, 8'h00, 8'h00};
    directed = {directed, slpd_pkg::SYNC_FIRST, slpd_pkg::SYNC_SECOND, 8'h02, 8'h01};
    // A sync byte as ordinary payload; the frame stays open across a register change.
    directed = {directed, slpd_pkg::SYNC_FIRST, slpd_pkg::SYNC_SECOND, 8'h00, 8'h03,
                slpd_pkg::SYNC_FIRST};
    stim_q = directed;
    stream_bytes();

    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(slpd_pkg::CFG_MAX_LEN, max_tbl[p]);
      write_reg(slpd_pkg::CFG_RESYNC, thr_tbl[p]);
      idle_max = gap_tbl[p];
      plan_traffic(size_tbl[p], 32'(max_tbl[p]),
                   (thr_tbl[p] > 16'd30) ? 32'd31 : 32'(thr_tbl[p]));
      stream_bytes();
    end

    settle();
    repeat (6) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/slpd_pkg.sv
src/sync_length_prefixed_deframer.sv
src/slpd_checker.sv
tb/sv/tb.sv
